### design/qts_pkg.sv
// Shared constants, types and the sine table builder for the queued tone synthesizer.
package qts_pkg;

  localparam int SAMPLE_RATE     = 44100;
  localparam int SINE_TABLE_SIZE = 1024;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int AMP_RESET       = 28000;
  localparam int DUR_DIV         = 1000;

  localparam int FREQ_W    = 15;
  localparam int DUR_W     = 16;
  localparam int SAMPLE_W  = 16;
  localparam int PEND_W    = 5;
  localparam int AMP_W     = 15;
  localparam int LEN_W     = 22;
  localparam int PHASE_W   = $clog2(SAMPLE_RATE);
  localparam int TAB_IDX_W = $clog2(SINE_TABLE_SIZE);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_AMPLITUDE = 1'b0;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SAMPLE_W-1:0] sine_tab_t [SINE_TABLE_SIZE];

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [LEN_W-1:0]  remain;
  } q_entry_t;

  // sin(x) in Q30 for x in [0, pi/2], six Taylor correction terms
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    return $unsigned(sum);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] u;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] theta;
    logic [63:0] s;
    logic [63:0] mag;
    for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
      u     = 64'(4 * k);
      quad  = u / SINE_TABLE_SIZE;
      rem   = u % SINE_TABLE_SIZE;
      theta = (HALF_PI_Q30 * rem) / SINE_TABLE_SIZE;
      if (quad[0]) begin
        theta = HALF_PI_Q30 - theta;
      end
      s   = sin_q30(theta);
      mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      tab[k] = (quad >= 64'd2) ? -$signed(SAMPLE_W'(mag)) : $signed(SAMPLE_W'(mag));
    end
    return tab;
  endfunction

endpackage

### design/qts_if.sv
// Request and result channel interfaces of the queued tone synthesizer.
interface qts_in_if;
  import qts_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [FREQ_W-1:0] tone_freq;
  logic [DUR_W-1:0]  duration_ms;
  modport source(output valid, action, tone_freq, duration_ms, input ready);
  modport sink(input valid, action, tone_freq, duration_ms, output ready);
endinterface

interface qts_out_if;
  import qts_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       accepted;
  logic [PEND_W-1:0]          tones_pending;
  modport source(output valid, sample, accepted, tones_pending, input ready);
  modport sink(input valid, sample, accepted, tones_pending, output ready);
endinterface

### design/qts_cfg.sv
// APB-style register block holding the output amplitude.
module qts_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [qts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [qts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [qts_pkg::AMP_W-1:0]      amplitude
);
  import qts_pkg::*;

  logic [AMP_W-1:0] amp_r;
  logic [AMP_W-1:0] amp_nxt;
  logic             wr_en;

  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_AMPLITUDE);

  always_comb begin
    amp_nxt = amp_r;
    if (wr_en) begin
      amp_nxt = pwdata[AMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= AMP_W'(AMP_RESET);
    end else begin
      amp_r <= amp_nxt;
    end
  end

  assign prdata    = (paddr[2] == REG_AMPLITUDE) ? CFG_DATA_W'(amp_r) : '0;
  assign pready    = 1'b1;
  assign amplitude = amp_r;

endmodule

### design/qts_sine.sv
// Phase to table index, sine ROM lookup and amplitude scaling pipeline.
module qts_sine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [qts_pkg::PHASE_W-1:0]       phase,
  input  logic [qts_pkg::AMP_W-1:0]         amplitude,
  output logic                              valid,
  output logic signed [qts_pkg::SAMPLE_W-1:0] sample
);
  import qts_pkg::*;

  // index = floor(phase * SINE_TABLE_SIZE / SAMPLE_RATE) by reciprocal and one correction
  localparam int IDX_SH  = PHASE_W + 4;
  localparam int RECIP_W = IDX_SH + TAB_IDX_W - PHASE_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << (IDX_SH + TAB_IDX_W)) / SAMPLE_RATE);
  localparam int PR_W    = PHASE_W + RECIP_W;
  localparam int SCL_W   = PHASE_W + TAB_IDX_W;
  localparam int MUL_W   = 2 * AMP_W;
  localparam sine_tab_t SINE_TAB = build_sine();

  logic [3:0]                 vld_r;
  logic [PHASE_W-1:0]         p1_r;
  logic [PR_W-1:0]            pr1_r;
  logic [TAB_IDX_W-1:0]       idx_r;
  logic signed [SAMPLE_W-1:0] tab_r;
  logic                       neg_r;
  logic [MUL_W-1:0]           mul_r;

  logic [TAB_IDX_W-1:0]       q0;
  logic [SCL_W-1:0]           scl_rem;
  logic [AMP_W-1:0]           mag;
  logic [AMP_W-1:0]           scaled;

  assign q0      = TAB_IDX_W'(pr1_r >> IDX_SH);
  assign scl_rem = {p1_r, {TAB_IDX_W{1'b0}}} - SCL_W'(SCL_W'(q0) * SCL_W'(SAMPLE_RATE));
  assign mag     = tab_r[SAMPLE_W-1] ? AMP_W'(-tab_r) : AMP_W'(tab_r);
  assign scaled  = mul_r[MUL_W-1:AMP_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= phase;
    pr1_r <= PR_W'(phase) * PR_W'(RECIP);
    idx_r <= (scl_rem >= SCL_W'(SAMPLE_RATE)) ? q0 + 1'b1 : q0;
    tab_r <= SINE_TAB[idx_r];
    neg_r <= tab_r[SAMPLE_W-1];
    mul_r <= MUL_W'(mag) * MUL_W'(amplitude);
  end

  assign valid  = vld_r[3];
  assign sample = neg_r ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});

endmodule

### design/qts_core.sv
// Tone queue memory, sequencer, length conversion, phase accumulator and result register.
module qts_core #(
  parameter int QUEUE_DEPTH = qts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  qts_in_if.sink                              in_ch,
  qts_out_if.source                           out_ch,
  output logic                                sine_start,
  output logic [qts_pkg::PHASE_W-1:0]         sine_phase,
  input  logic                                sine_valid,
  input  logic signed [qts_pkg::SAMPLE_W-1:0] sine_sample
);
  import qts_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // length = floor(duration_ms * SAMPLE_RATE / 1000) by reciprocal and one correction
  localparam int LEN_PROD_W = DUR_W + PHASE_W;
  localparam int DUR_RCP_W  = LEN_PROD_W - $clog2(DUR_DIV) + 1;
  localparam logic [DUR_RCP_W-1:0] DUR_RCP =
      DUR_RCP_W'((64'd1 << LEN_PROD_W) / DUR_DIV);
  localparam int LRQ_W   = LEN_PROD_W + DUR_RCP_W;
  localparam int PSUM_W  = PHASE_W + 1;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_LEN_MUL   = 3'd1;
  localparam logic [2:0] ST_LEN_RCP   = 3'd2;
  localparam logic [2:0] ST_LEN_FIX   = 3'd3;
  localparam logic [2:0] ST_PUSH      = 3'd4;
  localparam logic [2:0] ST_TICK_RMW  = 3'd5;
  localparam logic [2:0] ST_TICK_WAIT = 3'd6;
  localparam logic [2:0] ST_DONE      = 3'd7;

  q_entry_t qmem [QUEUE_DEPTH];
  q_entry_t rd_r;

  logic [2:0]                 state_r, state_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [IDX_W-1:0]           tail_r, tail_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [FREQ_W-1:0]          freq_r;
  logic [DUR_W-1:0]           dur_r;
  logic [LEN_PROD_W-1:0]      lenp_r;
  logic [LRQ_W-1:0]           lrq_r;
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic signed [SAMPLE_W-1:0] res_sample_r, res_sample_nxt;
  logic                       res_acc_r, res_acc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_acc_r;
  logic [PEND_W-1:0]          out_pend_r;

  logic                       in_take;
  logic                       out_load;
  logic                       rd_en;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  q_entry_t                   wr_data;
  logic [LEN_W-1:0]           len_q0;
  logic [LEN_PROD_W-1:0]      len_chk;
  logic [LEN_W-1:0]           rem_dec;
  logic [PSUM_W-1:0]          psum;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign len_q0  = LEN_W'(lrq_r >> LEN_PROD_W);
  assign len_chk = lenp_r - LEN_PROD_W'(LEN_PROD_W'(len_q0) * LEN_PROD_W'(DUR_DIV));
  assign rem_dec = (rd_r.remain != '0) ? rd_r.remain - 1'b1 : '0;
  assign psum    = PSUM_W'(phase_r) + PSUM_W'(rd_r.freq);

  // sample pipeline starts on the accepting edge from the current phase
  assign sine_start = in_take && in_ch.action && (cnt_r != '0);
  assign sine_phase = phase_r;
  assign rd_en      = sine_start;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    len_nxt        = len_r;
    res_sample_nxt = res_sample_r;
    res_acc_nxt    = res_acc_r;
    wr_en          = 1'b0;
    wr_addr        = tail_r;
    wr_data        = '{freq: freq_r, remain: len_r};
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          res_sample_nxt = '0;
          res_acc_nxt    = 1'b1;
          if (!in_ch.action) begin
            state_nxt = ST_LEN_MUL;
          end else if (cnt_r != '0) begin
            state_nxt = ST_TICK_RMW;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_LEN_MUL: begin
        state_nxt = ST_LEN_RCP;
      end
      ST_LEN_RCP: begin
        state_nxt = ST_LEN_FIX;
      end
      ST_LEN_FIX: begin
        len_nxt   = (len_chk >= LEN_PROD_W'(DUR_DIV)) ? len_q0 + 1'b1 : len_q0;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        // zero length changes nothing, even on a full queue
        if (len_r != '0) begin
          if (cnt_r == FULL_CNT) begin
            res_acc_nxt = 1'b0;
          end else begin
            wr_en    = 1'b1;
            tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        state_nxt = ST_DONE;
      end
      ST_TICK_RMW: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        wr_data   = '{freq: rd_r.freq, remain: rem_dec};
        phase_nxt = (psum >= PSUM_W'(SAMPLE_RATE)) ? PHASE_W'(psum - PSUM_W'(SAMPLE_RATE))
                                                   : PHASE_W'(psum);
        if (rem_dec == '0) begin
          head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
        end
        state_nxt = ST_TICK_WAIT;
      end
      ST_TICK_WAIT: begin
        if (sine_valid) begin
          res_sample_nxt = sine_sample;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      freq_r <= in_ch.tone_freq;
      dur_r  <= in_ch.duration_ms;
    end
    lenp_r       <= LEN_PROD_W'(dur_r) * LEN_PROD_W'(SAMPLE_RATE);
    lrq_r        <= LRQ_W'(lenp_r) * LRQ_W'(DUR_RCP);
    len_r        <= len_nxt;
    res_sample_r <= res_sample_nxt;
    res_acc_r    <= res_acc_nxt;
    if (out_load) begin
      out_sample_r <= res_sample_r;
      out_acc_r    <= res_acc_r;
      out_pend_r   <= PEND_W'(cnt_r);
    end
  end

  // queue store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      qmem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= qmem[head_r];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample        = out_sample_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.tones_pending = out_pend_r;

endmodule

### design/queued_tone_synthesizer.sv
// Top level of the queued tone synthesizer: register block, queue sequencer and sine unit.
//
//   channel  direction  handshake              payload
//   in_ch    in         valid / ready          action, tone_freq, duration_ms
//   out_ch   out        valid / ready          sample, accepted, tones_pending
//   APB      in         psel, penable, pready  paddr, pwdata -> prdata (amplitude)
//
// One request is worked at a time: a queue request passes a three-step length multiply
// chain before its result, a sample tick the four-stage index, sine ROM and amplitude
// pipeline, and a tick on an empty queue goes straight to the result.
// The result register frees the input side; a new request is taken once the previous
// result is in the result register. Synchronous reset clears phase, queue pointers and count.
module queued_tone_synthesizer #(
  parameter int QUEUE_DEPTH = qts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  qts_in_if.sink                         in_ch,
  qts_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [qts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [qts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import qts_pkg::*;

  logic [AMP_W-1:0]           amplitude;
  logic                       sine_start;
  logic [PHASE_W-1:0]         sine_phase;
  logic                       sine_valid;
  logic signed [SAMPLE_W-1:0] sine_sample;

  qts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .amplitude (amplitude)
  );

  qts_sine u_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sine_start),
    .phase     (sine_phase),
    .amplitude (amplitude),
    .valid     (sine_valid),
    .sample    (sine_sample)
  );

  qts_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .sine_start  (sine_start),
    .sine_phase  (sine_phase),
    .sine_valid  (sine_valid),
    .sine_sample (sine_sample)
  );

endmodule
